[hw/rtl/rotor_reflector_nibble_cipher_macros.svh]
// assertion macros shared by the rotor cipher rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ROTOR_REFLECTOR_NIBBLE_CIPHER_MACROS_SVH
`define ROTOR_REFLECTOR_NIBBLE_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
// check prop at every rising edge while reset is released
`define RRNC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check prop at every rising edge, reset included
`define RRNC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRNC_ASSERT(lbl, clk, rstn, prop, msg)
`define RRNC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/rrnc_pkg.sv]
// types, constants and lookup functions of the rotor cipher
// no dependencies
package rrnc_pkg;

  localparam int unsigned SymW      = 4;
  localparam int unsigned NumSyms   = 16;
  localparam int unsigned TableW    = SymW * NumSyms;
  localparam int unsigned StartW    = 3 * SymW;
  localparam int unsigned DataW     = 64;
  localparam int unsigned AddrW     = 5;
  localparam logic [TableW-1:0] IdentityWiring = 64'hFEDC_BA98_7654_3210;

  typedef logic [SymW-1:0] sym_t;

  typedef enum logic [1:0] {
    RegRotorOne   = 2'd0,
    RegRotorTwo   = 2'd1,
    RegRotorThree = 2'd2,
    RegStart      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    sym_t slow;
    sym_t middle;
    sym_t fast;
  } pos_t;

  typedef struct packed {
    logic [TableW-1:0] rotor_one;
    logic [TableW-1:0] rotor_two;
    logic [TableW-1:0] rotor_three;
    pos_t              start;
  } cfg_t;

  function automatic sym_t rotor_fwd(logic [TableW-1:0] wiring, sym_t idx);
    rotor_fwd = wiring[idx*SymW +: SymW];
  endfunction

  // lowest index whose entry matches, zero when nothing matches
  function automatic sym_t rotor_inv(logic [TableW-1:0] wiring, sym_t target);
    sym_t res;
    res = '0;
    for (int i = NumSyms - 1; i >= 0; i--) begin
      if (wiring[i*SymW +: SymW] == target) begin
        res = sym_t'(i);
      end
    end
    rotor_inv = res;
  endfunction

  function automatic sym_t reflect(sym_t x);
    sym_t r;
    case (x)
      4'h0:    r = 4'ha;
      4'h1:    r = 4'h5;
      4'h2:    r = 4'h7;
      4'h3:    r = 4'hf;
      4'h4:    r = 4'hd;
      4'h5:    r = 4'h1;
      4'h6:    r = 4'hb;
      4'h7:    r = 4'h2;
      4'h8:    r = 4'he;
      4'h9:    r = 4'hc;
      4'ha:    r = 4'h0;
      4'hb:    r = 4'h6;
      4'hc:    r = 4'h9;
      4'hd:    r = 4'h4;
      4'he:    r = 4'h8;
      4'hf:    r = 4'h3;
      default: r = 4'h0;
    endcase
    reflect = r;
  endfunction

endpackage

[hw/rtl/rrnc_if.sv]
// valid/ready stream interfaces for the cipher's input and result channels
// depends on rrnc_pkg
interface rrnc_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  rrnc_pkg::sym_t     symbol_in;

  modport source (output valid, output command, output symbol_in, input ready);
  modport sink   (input valid, input command, input symbol_in, output ready);
endinterface

interface rrnc_out_if;
  logic               valid;
  logic               ready;
  rrnc_pkg::sym_t     symbol_out;

  modport source (output valid, output symbol_out, input ready);
  modport sink   (input valid, input symbol_out, output ready);
endinterface

[hw/rtl/rrnc_cfg.sv]
// apb-style register file holding the rotor wirings and start positions
// depends on rrnc_pkg
module rrnc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrnc_pkg::AddrW-1:0]    paddr,
  input  logic [rrnc_pkg::DataW-1:0]    pwdata,
  output logic [rrnc_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output rrnc_pkg::cfg_t                cfg_o
);

  rrnc_pkg::cfg_t     cfg_q;
  rrnc_pkg::reg_idx_e idx;
  logic               wr_en;

  // registers sit 8 bytes apart
  assign idx    = rrnc_pkg::reg_idx_e'(paddr[rrnc_pkg::AddrW-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotor_one   <= rrnc_pkg::IdentityWiring;
      cfg_q.rotor_two   <= rrnc_pkg::IdentityWiring;
      cfg_q.rotor_three <= rrnc_pkg::IdentityWiring;
      cfg_q.start       <= '0;
    end else if (wr_en) begin
      case (idx)
        rrnc_pkg::RegRotorOne:   cfg_q.rotor_one   <= pwdata;
        rrnc_pkg::RegRotorTwo:   cfg_q.rotor_two   <= pwdata;
        rrnc_pkg::RegRotorThree: cfg_q.rotor_three <= pwdata;
        rrnc_pkg::RegStart:      cfg_q.start       <= pwdata[rrnc_pkg::StartW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rrnc_pkg::RegRotorOne:   prdata = cfg_q.rotor_one;
      rrnc_pkg::RegRotorTwo:   prdata = cfg_q.rotor_two;
      rrnc_pkg::RegRotorThree: prdata = cfg_q.rotor_three;
      rrnc_pkg::RegStart:      prdata = rrnc_pkg::DataW'(cfg_q.start);
      default:                 prdata = '0;
    endcase
  end

endmodule

[hw/rtl/rrnc_rotor_path.sv]
// rotor/reflector lookup chain feeding the result register
// depends on rrnc_pkg
module rrnc_rotor_path (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               take_i,
  input  logic               reload_i,
  input  rrnc_pkg::sym_t     symbol_i,
  input  rrnc_pkg::pos_t     pos_i,
  input  rrnc_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  output rrnc_pkg::sym_t     symbol_o
);

  rrnc_pkg::sym_t p1, p2, p3;
  rrnc_pkg::sym_t a, b, c, f, cr, br, ar;
  rrnc_pkg::sym_t res_d, res_q;
  logic           valid_d, valid_q;

  assign p1 = pos_i.fast;
  assign p2 = pos_i.middle;
  assign p3 = pos_i.slow;

  // forward through the rotors, reflect, then back through inverse wirings; zero on a reload
  always_comb begin
    a  = rrnc_pkg::rotor_fwd(cfg_i.rotor_one,   rrnc_pkg::SymW'(symbol_i + p1));
    b  = rrnc_pkg::rotor_fwd(cfg_i.rotor_two,   rrnc_pkg::SymW'(a + p2 - p1));
    c  = rrnc_pkg::rotor_fwd(cfg_i.rotor_three, rrnc_pkg::SymW'(b + p3 - p2));
    f  = rrnc_pkg::reflect(rrnc_pkg::SymW'(c - p3));
    cr = rrnc_pkg::rotor_inv(cfg_i.rotor_three, rrnc_pkg::SymW'(f + p3));
    br = rrnc_pkg::rotor_inv(cfg_i.rotor_two,   rrnc_pkg::SymW'(cr + p2 - p3));
    ar = rrnc_pkg::rotor_inv(cfg_i.rotor_one,   rrnc_pkg::SymW'(br + p1 - p2));
    res_d = reload_i ? '0 : rrnc_pkg::SymW'(ar - p1);
  end

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign symbol_o = res_q;

endmodule

[hw/rtl/rotor_reflector_nibble_cipher.sv]
// Three-rotor, one-reflector nibble cipher over a 16-symbol alphabet.
// Input channel in_i (valid/ready): command 0 enciphers symbol_in, command 1
// reloads the rotor positions from the start_positions register and gives 0.
// Result channel out_o (valid/ready) carries one symbol_out per input item,
// in order. A transfer happens when valid and ready are both high.
// The item is captured in an input register together with the stepped rotor
// positions, or the start positions on a reload; the lookup chain (three
// forward rotors, the reflector, three inverse searches) sits between that
// register and the result register, from which out_o is driven.
// Throughput: one item per cycle while out_o.ready is high, set by the
// combinational lookup chain. A stalled receiver holds the result; the
// input register still takes one more item, after which in_i.ready drops
// until the result moves.
// Reset clears the positions to 0, the wirings to identity, the start
// positions to 0, and empties both stages. The apb-style port writes the
// wirings at byte 0, 8, 16 and the start positions at byte 24; write
// configuration only while no item is in flight.
// depends on rrnc_pkg, rrnc_if, rrnc_cfg, rrnc_rotor_path and rotor_reflector_nibble_cipher_macros.svh
`include "rotor_reflector_nibble_cipher_macros.svh"

module rotor_reflector_nibble_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rrnc_in_if.sink                     in_i,
  rrnc_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrnc_pkg::AddrW-1:0]  paddr,
  input  logic [rrnc_pkg::DataW-1:0]  pwdata,
  output logic [rrnc_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  rrnc_pkg::cfg_t cfg;
  rrnc_pkg::pos_t pos_d, pos_q, pos_step;
  rrnc_pkg::sym_t sym_q;
  logic           cmd_q;
  logic           s1_valid_d, s1_valid_q;
  logic           res_valid, out_free, s1_adv, in_fire;

  rrnc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free   = !res_valid || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  // odometer stepping; fast rotor always moves
  always_comb begin
    pos_step.fast   = rrnc_pkg::SymW'(pos_q.fast + 1'b1);
    pos_step.middle = pos_q.middle;
    pos_step.slow   = pos_q.slow;
    if (pos_step.fast == '0) begin
      pos_step.middle = rrnc_pkg::SymW'(pos_q.middle + 1'b1);
      if (pos_step.middle == '0) begin
        pos_step.slow = rrnc_pkg::SymW'(pos_q.slow + 1'b1);
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (in_fire) begin
      pos_d = in_i.command ? cfg.start : pos_step;
    end
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_i.command;
      sym_q <= in_i.symbol_in;
    end
  end

  // pos_q only moves on an input transfer, so it still holds the held item's positions
  rrnc_rotor_path u_path (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s1_adv),
    .take_i   (out_o.ready),
    .reload_i (cmd_q),
    .symbol_i (sym_q),
    .pos_i    (pos_q),
    .cfg_i    (cfg),
    .valid_o  (res_valid),
    .symbol_o (out_o.symbol_out)
  );

  assign out_o.valid = res_valid;

  `RRNC_ASSERT(a_reload_pos, clk_i, rst_ni, in_fire && in_i.command |=> pos_q == $past(cfg.start), "reload did not load start positions")
  `RRNC_ASSERT(a_fast_step, clk_i, rst_ni, in_fire && !in_i.command |=> pos_q.fast == rrnc_pkg::SymW'($past(pos_q.fast) + 1'b1), "fast rotor did not step")
  `RRNC_ASSERT(a_pos_hold, clk_i, rst_ni, !in_fire |=> $stable(pos_q), "positions moved without a transfer")
  `RRNC_ASSERT(a_reload_zero, clk_i, rst_ni, s1_adv && cmd_q |=> out_o.symbol_out == '0, "reload result not zero")
  `RRNC_ASSERT(a_no_overrun, clk_i, rst_ni, s1_valid_q && !out_free |-> !in_i.ready, "input taken while stage one is blocked")

endmodule
